// ===== src/tllc_pkg.sv =====
// Package for the two-level LRU cache latency model.
// Holds the payload structs, register indexes and state codes; no dependencies.
package tllc_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [16:0] access_time;
        logic        first_level_hit;
        logic        second_level_used;
        logic        second_level_hit;
    } t_rsp;

    localparam logic [2:0] REG_OFFSET   = 3'd0;
    localparam logic [2:0] REG_L1I_WAYS = 3'd1;
    localparam logic [2:0] REG_L1D_WAYS = 3'd2;
    localparam logic [2:0] REG_L2_WAYS  = 3'd3;
    localparam logic [2:0] REG_L1I_TIME = 3'd4;
    localparam logic [2:0] REG_L1D_TIME = 3'd5;
    localparam logic [2:0] REG_L2_TIME  = 3'd6;
    localparam logic [2:0] REG_MEM_LAT  = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L1_READ,
        ST_L1_UPD,
        ST_L2_READ,
        ST_L2_UPD,
        ST_OUT
    } t_state;

endpackage

// ===== src/tllc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tllc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/two_level_lru_cache_latency_model.sv =====
// Top level of the two-level LRU cache latency model.
// Depends on tllc_pkg and tllc_ram.
//
// Each request word carries an address and an instruction/data flag. The
// block looks the address up in the selected first-level tag store and, on
// a miss or when that level has no ways, in the shared second-level store,
// and returns one response word with the total access time and hit flags.
// Every store keeps one row per set: the tags, valid bits and LRU ranks of
// all ways together, so a lookup is one read and one write of a row. A
// request is taken in ST_IDLE and passes through ST_L1_READ, then ST_L1_UPD
// when the first level has ways, then ST_L2_READ and ST_L2_UPD when it goes
// on to the second level (ST_L2_UPD only when that level has ways), and ends
// in ST_OUT. The response word becomes valid as the block returns to
// ST_IDLE, in the same cycle in which the next request can be taken;
// while an earlier response still waits for the receiver, the block holds the
// new one and takes no request. After reset a clearing pass writes one row
// of each of the three stores per cycle until it has covered
// max(INST_SETS, DATA_SETS, SECOND_SETS) rows
// (1024 by default); no request is taken during the pass. Configuration writes
// are always accepted, but must only be made while no request is in flight.
module two_level_lru_cache_latency_model
    import tllc_pkg::*;
#(
    parameter int INST_SETS   = 256,
    parameter int DATA_SETS   = 256,
    parameter int SECOND_SETS = 1024,
    parameter int MAX_WAYS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    // Widths derived from the parameters.
    localparam int IIB = $clog2(INST_SETS);
    localparam int DIB = $clog2(DATA_SETS);
    localparam int SIB = $clog2(SECOND_SETS);
    localparam int IAW = (IIB > 0) ? IIB : 1;
    localparam int DAW = (DIB > 0) ? DIB : 1;
    localparam int SAW = (SIB > 0) ? SIB : 1;
    localparam int RW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WW  = $clog2(MAX_WAYS + 1);
    localparam int ENT = 32 + 1 + RW;
    localparam int ROW = MAX_WAYS * ENT;
    localparam int MAXS = (SECOND_SETS > INST_SETS) ?
        ((SECOND_SETS > DATA_SETS) ? SECOND_SETS : DATA_SETS) :
        ((INST_SETS > DATA_SETS) ? INST_SETS : DATA_SETS);
    localparam int CW = $clog2(MAXS + 1);
    localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);

    typedef struct packed {
        logic [31:0]   tag;
        logic          vld;
        logic [RW-1:0] rank;
    } t_ent;

    // Configuration registers.
    logic [3:0]  r_off, r_l1i_w, r_l1d_w, r_l2_w;
    logic [7:0]  r_l1i_t, r_l1d_t, r_l2_t;
    logic [15:0] r_mem_lat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= 4'd6; r_l1i_w <= 4'd4; r_l1d_w <= 4'd4; r_l2_w <= 4'd8;
            r_l1i_t <= 8'd1; r_l1d_t <= 8'd1; r_l2_t <= 8'd10;
            r_mem_lat <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OFFSET:   r_off     <= i_cfg_data[3:0];
                REG_L1I_WAYS: r_l1i_w   <= i_cfg_data[3:0];
                REG_L1D_WAYS: r_l1d_w   <= i_cfg_data[3:0];
                REG_L2_WAYS:  r_l2_w    <= i_cfg_data[3:0];
                REG_L1I_TIME: r_l1i_t   <= i_cfg_data[7:0];
                REG_L1D_TIME: r_l1d_t   <= i_cfg_data[7:0];
                REG_L2_TIME:  r_l2_t    <= i_cfg_data[7:0];
                REG_MEM_LAT:  r_mem_lat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control and request registers.
    t_state       r_state, n_state;
    logic [CW-1:0] r_clr;
    logic [31:0]  r_addr;
    logic         r_is_data;
    logic [16:0]  r_time;
    logic         r_l1hit, r_l2used, r_l2hit;
    logic [WW-1:0] r_ways;
    logic [31:0]  r_tag;
    t_rsp         r_rsp;
    logic         r_rsp_valid;

    function automatic logic [WW-1:0] cap(input logic [3:0] w);
        cap = (32'(w) > MAX_WAYS) ? WW'(MAX_WAYS) : WW'(w);
    endfunction

    // Tag of the given address for a store of 2**ib sets.
    function automatic logic [31:0] tag_of(input logic [31:0] a, input logic [3:0] off,
                                           input int ib);
        logic [5:0] sh;
        sh = 6'(off) + 6'(ib);
        tag_of = (sh >= 6'd32) ? 32'd0 : (a >> sh);
    endfunction

    logic [31:0] addr_sh;
    assign addr_sh = r_addr >> r_off;

    // Row memories.
    logic            we_i, we_d, we_s;
    logic [IAW-1:0]  ra_i, wa_i;
    logic [DAW-1:0]  ra_d, wa_d;
    logic [SAW-1:0]  ra_s, wa_s;
    logic [ROW-1:0]  rd_i, rd_d, rd_s, wrow, wd_i, wd_d, wd_s;
    logic            clearing;

    assign clearing = (r_state == ST_CLEAR);
    assign ra_i = (IIB > 0) ? IAW'(addr_sh) : '0;
    assign ra_d = (DIB > 0) ? DAW'(addr_sh) : '0;
    assign ra_s = (SIB > 0) ? SAW'(addr_sh) : '0;
    assign wa_i = clearing ? IAW'(r_clr) : ra_i;
    assign wa_d = clearing ? DAW'(r_clr) : ra_d;
    assign wa_s = clearing ? SAW'(r_clr) : ra_s;
    assign wd_i = clearing ? '0 : wrow;
    assign wd_d = clearing ? '0 : wrow;
    assign wd_s = clearing ? '0 : wrow;
    assign we_i = clearing || (r_state == ST_L1_UPD && !r_is_data);
    assign we_d = clearing || (r_state == ST_L1_UPD && r_is_data);
    assign we_s = clearing || (r_state == ST_L2_UPD);

    tllc_ram #(.WIDTH(ROW), .DEPTH(2 ** IIB)) u_inst (
        .i_clk, .i_we(we_i), .i_waddr(wa_i), .i_wdata(wd_i), .i_raddr(ra_i), .o_rdata(rd_i));
    tllc_ram #(.WIDTH(ROW), .DEPTH(2 ** DIB)) u_data (
        .i_clk, .i_we(we_d), .i_waddr(wa_d), .i_wdata(wd_d), .i_raddr(ra_d), .o_rdata(rd_d));
    tllc_ram #(.WIDTH(ROW), .DEPTH(2 ** SIB)) u_second (
        .i_clk, .i_we(we_s), .i_waddr(wa_s), .i_wdata(wd_s), .i_raddr(ra_s), .o_rdata(rd_s));

    // LRU update of one row.
    logic [ROW-1:0] row_in;
    t_ent           ent    [MAX_WAYS];
    t_ent           nent   [MAX_WAYS];
    logic [MAX_WAYS-1:0] hitv, act, inv;
    logic           hit;
    logic [RW-1:0]  hway, iway, vway, tway, lim, hrank;
    logic           have_inv;

    assign row_in = (r_state == ST_L2_UPD) ? rd_s : (r_is_data ? rd_d : rd_i);

    always_comb begin
        hit = 1'b0; hway = '0; have_inv = 1'b0; iway = '0; vway = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            ent[w]  = row_in[w*ENT +: ENT];
            act[w]  = (WW'(w) < r_ways);
            hitv[w] = act[w] && ent[w].vld && (ent[w].tag == r_tag);
            inv[w]  = act[w] && !ent[w].vld;
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) begin hit = 1'b1; hway = RW'(w); end
            if (inv[w]) begin have_inv = 1'b1; iway = RW'(w); end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (act[w] && ent[w].rank > ent[vway].rank) vway = RW'(w);
        end
        hrank = ent[hway].rank;
        tway  = hit ? hway : (have_inv ? iway : vway);
        lim   = hit ? hrank : (have_inv ? RMAX : ent[vway].rank);
        for (int w = 0; w < MAX_WAYS; w++) begin
            nent[w] = ent[w];
            if (RW'(w) == tway) begin
                nent[w].rank = '0;
                if (!hit) begin
                    nent[w].tag = r_tag;
                    nent[w].vld = 1'b1;
                end
            end else if (act[w] && ent[w].vld && ent[w].rank < lim) begin
                nent[w].rank = ent[w].rank + 1'b1;
            end
            wrow[w*ENT +: ENT] = nent[w];
        end
    end

    // Sequencer.
    logic [WW-1:0] l1w, l2w;
    assign l1w = cap(i_req.req_type ? r_l1d_w : r_l1i_w);
    assign l2w = cap(r_l2_w);

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr == CW'(MAXS - 1)) n_state = ST_IDLE;
            ST_IDLE:    if (i_req_valid) n_state = ST_L1_READ;
            ST_L1_READ: n_state = (r_ways == '0) ? ST_L2_READ : ST_L1_UPD;
            ST_L1_UPD:  n_state = hit ? ST_OUT : ST_L2_READ;
            ST_L2_READ: n_state = (r_ways == '0) ? ST_OUT : ST_L2_UPD;
            ST_L2_UPD:  n_state = ST_OUT;
            ST_OUT:     if (!r_rsp_valid || i_rsp_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
            if (r_state == ST_OUT && (!r_rsp_valid || i_rsp_ready)) r_rsp_valid <= 1'b1;
            else if (r_rsp_valid && i_rsp_ready) r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_addr    <= i_req.address;
                r_is_data <= i_req.req_type;
                r_ways    <= l1w;
                r_tag     <= tag_of(i_req.address, r_off, i_req.req_type ? DIB : IIB);
                r_time    <= '0;
                r_l1hit <= 1'b0; r_l2used <= 1'b0; r_l2hit <= 1'b0;
            end
            ST_L1_READ: begin
                if (r_ways != '0)
                    r_time <= 17'(r_is_data ? r_l1d_t : r_l1i_t);
                else begin
                    r_ways <= l2w;
                    r_tag  <= tag_of(r_addr, r_off, SIB);
                end
            end
            ST_L1_UPD: begin
                r_l1hit <= hit;
                r_ways  <= l2w;
                r_tag   <= tag_of(r_addr, r_off, SIB);
            end
            ST_L2_READ: begin
                if (r_ways == '0) r_time <= r_time + 17'(r_mem_lat);
                else r_time <= r_time + 17'(r_l2_t);
            end
            ST_L2_UPD: begin
                r_l2used <= 1'b1;
                r_l2hit  <= hit;
                if (!hit) r_time <= r_time + 17'(r_mem_lat);
            end
            ST_OUT: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    r_rsp.access_time       <= r_time;
                    r_rsp.first_level_hit   <= r_l1hit;
                    r_rsp.second_level_used <= r_l2used;
                    r_rsp.second_level_hit  <= r_l2hit;
                end
            end
            default: ;
        endcase
    end

    // A response never claims a second-level hit without a second-level lookup.
    a_l2hit_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (!o_rsp.second_level_hit || o_rsp.second_level_used))
        else $error("second-level hit without lookup");
    // A first-level hit never goes on to the second level.
    a_l1hit_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.first_level_hit && o_rsp.second_level_used))
        else $error("first-level hit reached second level");
    // No request is taken while the stores are being cleared.
    a_no_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_req_ready)
        else $error("request accepted during clearing");
endmodule
